// ----- rtl/gmsca_pkg.sv -----
// Package for the chunk allocator: commands, status codes, states and the
// controller/datapath command and status structs. No dependencies.
package gmsca_pkg;

    localparam logic [1:0] CMD_ALLOC = 2'd0;
    localparam logic [1:0] CMD_FREE  = 2'd1;
    localparam logic [1:0] CMD_READ  = 2'd2;

    localparam logic [1:0] ST_OK       = 2'd0;
    localparam logic [1:0] ST_FAIL     = 2'd1;
    localparam logic [1:0] ST_BAD_READ = 2'd2;

    localparam logic [1:0] POOL_LARGE  = 2'd0;
    localparam logic [1:0] POOL_MEDIUM = 2'd1;
    localparam logic [1:0] POOL_SMALL  = 2'd2;

    localparam logic [31:0] BASE_RESET = 32'h8000_0000;

    typedef enum logic [3:0] {
        S_CLEAR,
        S_IDLE,
        S_SPLIT,
        S_TAKE,
        S_REMAIN,
        S_RELEASE,
        S_READ,
        S_READ_WAIT,
        S_DONE
    } t_state;

    typedef struct packed {
        logic       load;
        logic       clear_step;
        logic       split;
        logic       take_start;
        logic       take_step;
        logic       remain;
        logic       rel_start;
        logic       rel_step;
        logic       read_issue;
        logic       read_capture;
        logic       fail;
    } t_ctrl;

    typedef struct packed {
        logic clear_done;
        logic take_done;
        logic rel_done;
        logic remain_needed;
        logic small_ok;
    } t_stat;

endpackage

// ----- rtl/gmsca_datapath.sv -----
// Datapath of the chunk allocator: tag memories, free counters, length
// splitting and the scan index. Depends on gmsca_pkg.
module gmsca_datapath
    import gmsca_pkg::*;
#(
    parameter int LARGE_CHUNKS  = 16,
    parameter int MEDIUM_CHUNKS = 128,
    parameter int SMALL_CHUNKS  = 2048,
    parameter int OWNER_BITS    = 8
) (
    input  logic        i_clk,
    input  logic        i_rst_n,
    input  t_ctrl       i_ctrl,
    output t_stat       o_stat,
    input  logic [1:0]  i_cmd,
    input  logic [30:0] i_len,
    input  logic [7:0]  i_owner,
    input  logic [1:0]  i_psel,
    input  logic [10:0] i_idx,
    input  logic [31:0] i_base,
    output logic [1:0]  o_status,
    output logic [11:0] o_taken_total,
    output logic [4:0]  o_taken_large,
    output logic [7:0]  o_taken_medium,
    output logic [11:0] o_taken_small,
    output logic [4:0]  o_free_large,
    output logic [7:0]  o_free_medium,
    output logic [11:0] o_free_small,
    output logic        o_chunk_in_use,
    output logic [7:0]  o_chunk_owner,
    output logic [31:0] o_chunk_address
);

    localparam int LA = (LARGE_CHUNKS > 1) ? $clog2(LARGE_CHUNKS) : 1;
    localparam int MA = (MEDIUM_CHUNKS > 1) ? $clog2(MEDIUM_CHUNKS) : 1;
    localparam int SA = $clog2(SMALL_CHUNKS);
    localparam int TW = OWNER_BITS + 1;
    localparam int TOTAL = LARGE_CHUNKS + MEDIUM_CHUNKS + SMALL_CHUNKS;
    localparam int IW = $clog2(TOTAL + 1);
    localparam int WW = 20;
    localparam logic [IW-1:0] LAST = IW'(TOTAL - 1);
    localparam logic [IW-1:0] M0 = IW'(LARGE_CHUNKS);
    localparam logic [IW-1:0] S0 = IW'(LARGE_CHUNKS + MEDIUM_CHUNKS);
    localparam logic [31:0] MED_OFF = 32'(LARGE_CHUNKS * 64'h10_0000);
    localparam logic [31:0] SML_OFF = 32'(LARGE_CHUNKS * 64'h10_0000 +
                                          MEDIUM_CHUNKS * 64'h1_0000);

    logic [TW-1:0] r_large  [LARGE_CHUNKS];
    logic [TW-1:0] r_medium [MEDIUM_CHUNKS];
    logic [TW-1:0] r_small  [SMALL_CHUNKS];

    logic [OWNER_BITS-1:0] r_owner, n_owner;
    logic [1:0]  r_cmd, r_psel;
    logic [10:0] r_idx;
    logic [IW-1:0] r_pos;
    logic [IW-1:0] r_spare;
    logic [WW-1:0] r_want_l, r_want_m, r_want_s;
    logic [30:0] r_len;
    logic        r_rem;
    logic [IW-1:0] r_got_l, r_got_m, r_got_s;
    logic [IW-1:0] r_free_l, r_free_m, r_free_s;
    logic [TW-1:0] r_rd_l, r_rd_m, r_rd_s;
    logic [1:0]  r_status;
    logic [31:0] r_addr;
    logic        r_in_use;
    logic [OWNER_BITS-1:0] r_cowner;
    logic        r_single;

    logic [1:0]  pool;
    logic [IW-1:0] loc;
    logic [TW-1:0] tag;
    logic        hit_free, hit_own, need;
    logic [IW-1:0] got_cur;
    logic [WW-1:0] want_cur;

    assign n_owner = OWNER_BITS'(i_owner);

    always_comb begin
        if (r_pos < M0) begin
            pool = POOL_LARGE;
            loc = r_pos;
        end else if (r_pos < S0) begin
            pool = POOL_MEDIUM;
            loc = r_pos - M0;
        end else begin
            pool = POOL_SMALL;
            loc = r_pos - S0;
        end
        unique case (pool)
            POOL_LARGE: begin
                tag = r_rd_l;
                got_cur = r_got_l;
                want_cur = r_want_l;
            end
            POOL_MEDIUM: begin
                tag = r_rd_m;
                got_cur = r_got_m;
                want_cur = r_want_m;
            end
            default: begin
                tag = r_rd_s;
                got_cur = r_got_s;
                want_cur = r_want_s;
            end
        endcase
        hit_free = !tag[OWNER_BITS];
        hit_own = tag == {1'b1, r_owner};
        need = WW'(got_cur) < want_cur;
    end

    logic [IW-1:0] rd_pos;
    logic [IW-1:0] rd_loc;
    always_comb begin
        rd_pos = i_ctrl.take_start || i_ctrl.rel_start ? '0 : r_pos + 1'b1;
        if (rd_pos < M0) rd_loc = rd_pos;
        else if (rd_pos < S0) rd_loc = rd_pos - M0;
        else rd_loc = rd_pos - S0;
    end

    logic wr_en;
    logic [TW-1:0] wr_tag;
    always_comb begin
        wr_en = 1'b0;
        wr_tag = '0;
        if (i_ctrl.clear_step) begin
            wr_en = 1'b1;
        end else if (i_ctrl.take_step && hit_free && need) begin
            wr_en = 1'b1;
            wr_tag = {1'b1, r_owner};
        end else if (i_ctrl.remain && r_single) begin
            wr_en = 1'b1;
            wr_tag = {1'b1, r_owner};
        end else if (i_ctrl.rel_step && hit_own) begin
            wr_en = 1'b1;
        end
    end

    logic [IW-1:0] wr_loc;
    logic [1:0] wr_pool;
    assign wr_loc = i_ctrl.remain ? r_spare : loc;
    assign wr_pool = i_ctrl.remain ? POOL_SMALL : pool;

    logic [IW-1:0] rdi_loc;
    always_comb begin
        if (i_ctrl.read_issue) begin
            rdi_loc = IW'(r_idx);
        end else begin
            rdi_loc = rd_loc;
        end
    end

    always_ff @(posedge i_clk) begin
        if (wr_en && wr_pool == POOL_LARGE) r_large[wr_loc[LA-1:0]] <= wr_tag;
        if (wr_en && wr_pool == POOL_MEDIUM) r_medium[wr_loc[MA-1:0]] <= wr_tag;
        if (wr_en && wr_pool == POOL_SMALL) r_small[wr_loc[SA-1:0]] <= wr_tag;
        r_rd_l <= r_large[rdi_loc[LA-1:0]];
        r_rd_m <= r_medium[rdi_loc[MA-1:0]];
        r_rd_s <= r_small[rdi_loc[SA-1:0]];
    end

    // Shortfall in one pool rolls into the next pool's demand, in chunk units.
    logic [WW-1:0] got_next;
    logic [WW-1:0] carry;
    always_comb begin
        got_next = WW'(got_cur) + WW'(hit_free && need);
        carry = '0;
        if (i_ctrl.take_step && (r_pos == M0 - 1'b1 || r_pos == S0 - 1'b1) &&
            want_cur > got_next)
            carry = (want_cur - got_next) << 4;
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_pos <= '0;
            r_free_l <= IW'(LARGE_CHUNKS);
            r_free_m <= IW'(MEDIUM_CHUNKS);
            r_free_s <= IW'(SMALL_CHUNKS);
            r_single <= 1'b0;
        end else begin
            if (i_ctrl.clear_step || i_ctrl.take_step || i_ctrl.rel_step)
                r_pos <= r_pos + 1'b1;
            if (i_ctrl.take_start || i_ctrl.rel_start) r_pos <= '0;
            if (i_ctrl.load) begin
                r_owner <= n_owner;
                r_cmd <= i_cmd;
                r_psel <= i_psel;
                r_idx <= i_idx;
                r_len <= i_len;
                r_got_l <= '0;
                r_got_m <= '0;
                r_got_s <= '0;
                r_status <= ST_OK;
                r_single <= 1'b0;
            end
            if (i_ctrl.split) begin
                r_want_l <= WW'(r_len[30:20]);
                r_want_m <= WW'(r_len[19:16]);
                r_want_s <= WW'(r_len[15:12]);
                r_rem <= r_len[11:0] != 12'd0;
            end
            if (i_ctrl.take_step && r_pos == M0 - 1'b1)
                r_want_m <= r_want_m + carry;
            if (i_ctrl.take_step && r_pos == S0 - 1'b1)
                r_want_s <= r_want_s + carry;
            if (i_ctrl.take_step && hit_free && need) begin
                unique case (pool)
                    POOL_LARGE: begin
                        r_got_l <= r_got_l + 1'b1;
                        r_free_l <= r_free_l - 1'b1;
                    end
                    POOL_MEDIUM: begin
                        r_got_m <= r_got_m + 1'b1;
                        r_free_m <= r_free_m - 1'b1;
                    end
                    default: begin
                        r_got_s <= r_got_s + 1'b1;
                        r_free_s <= r_free_s - 1'b1;
                    end
                endcase
            end
            if (i_ctrl.take_step && hit_free && !need && pool == POOL_SMALL && !r_single)
            begin
                r_single <= 1'b1;
                r_spare <= loc;
            end
            if (i_ctrl.remain && r_single) begin
                r_got_s <= r_got_s + 1'b1;
                r_free_s <= r_free_s - 1'b1;
            end
            if (i_ctrl.rel_step && hit_own) begin
                unique case (pool)
                    POOL_LARGE:  r_free_l <= r_free_l + 1'b1;
                    POOL_MEDIUM: r_free_m <= r_free_m + 1'b1;
                    default:     r_free_s <= r_free_s + 1'b1;
                endcase
            end
            if (i_ctrl.fail) begin
                r_status <= ST_FAIL;
                r_got_l <= '0;
                r_got_m <= '0;
                r_got_s <= '0;
            end
            if (i_ctrl.read_capture) begin
                r_in_use <= 1'b0;
                r_cowner <= '0;
                r_addr <= '0;
                if (r_psel == 2'd3 ||
                    (r_psel == POOL_LARGE && 32'(r_idx) >= 32'(LARGE_CHUNKS)) ||
                    (r_psel == POOL_MEDIUM && 32'(r_idx) >= 32'(MEDIUM_CHUNKS)) ||
                    (r_psel == POOL_SMALL && 32'(r_idx) >= 32'(SMALL_CHUNKS))) begin
                    r_status <= ST_BAD_READ;
                end else begin
                    unique case (r_psel)
                        POOL_LARGE: begin
                            r_in_use <= r_rd_l[OWNER_BITS];
                            r_cowner <= r_rd_l[OWNER_BITS-1:0];
                            r_addr <= i_base + {1'b0, r_idx, 20'd0};
                        end
                        POOL_MEDIUM: begin
                            r_in_use <= r_rd_m[OWNER_BITS];
                            r_cowner <= r_rd_m[OWNER_BITS-1:0];
                            r_addr <= i_base + MED_OFF + {5'd0, r_idx, 16'd0};
                        end
                        default: begin
                            r_in_use <= r_rd_s[OWNER_BITS];
                            r_cowner <= r_rd_s[OWNER_BITS-1:0];
                            r_addr <= i_base + SML_OFF + {9'd0, r_idx, 12'd0};
                        end
                    endcase
                end
            end
        end
    end

    assign o_stat.clear_done = r_pos == LAST;
    assign o_stat.take_done = r_pos == LAST;
    assign o_stat.rel_done = r_pos == LAST;
    assign o_stat.remain_needed = r_rem || (WW'(r_got_s) < r_want_s);
    assign o_stat.small_ok = r_free_s > IW'(1) && r_single;

    logic show_taken;
    assign show_taken = r_cmd == CMD_ALLOC;
    assign o_status = r_status;
    assign o_taken_large = show_taken ? 5'(r_got_l) : '0;
    assign o_taken_medium = show_taken ? 8'(r_got_m) : '0;
    assign o_taken_small = show_taken ? 12'(r_got_s) : '0;
    assign o_taken_total = show_taken ? 12'(r_got_l + r_got_m + r_got_s) : '0;
    assign o_free_large = 5'(r_free_l);
    assign o_free_medium = 8'(r_free_m);
    assign o_free_small = 12'(r_free_s);
    assign o_chunk_in_use = r_cmd == CMD_READ && r_in_use;
    assign o_chunk_owner = r_cmd == CMD_READ ? 8'(r_cowner) : '0;
    assign o_chunk_address = r_cmd == CMD_READ ? r_addr : '0;

endmodule

// ----- rtl/gmsca_ctrl.sv -----
// Controller state machine of the chunk allocator. Sequences clear, take,
// remainder, release and read steps. Depends on gmsca_pkg.
module gmsca_ctrl
    import gmsca_pkg::*;
(
    input  logic       i_clk,
    input  logic       i_rst_n,
    input  logic       i_in_valid,
    input  logic [1:0] i_cmd,
    input  logic       i_out_ready,
    input  t_stat      i_stat,
    output t_ctrl      o_ctrl,
    output logic       o_in_ready,
    output logic       o_out_valid
);

    t_state r_state, n_state;
    logic r_fail, n_fail;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= S_CLEAR;
            r_fail <= 1'b0;
        end else begin
            r_state <= n_state;
            r_fail <= n_fail;
        end
    end

    always_comb begin
        n_state = r_state;
        n_fail = r_fail;
        o_ctrl = '0;
        o_in_ready = 1'b0;
        o_out_valid = 1'b0;
        unique case (r_state)
            S_CLEAR: begin
                o_ctrl.clear_step = 1'b1;
                if (i_stat.clear_done) n_state = S_IDLE;
            end
            S_IDLE: begin
                o_in_ready = 1'b1;
                if (i_in_valid) begin
                    o_ctrl.load = 1'b1;
                    n_fail = 1'b0;
                    unique case (i_cmd)
                        CMD_ALLOC: n_state = S_SPLIT;
                        CMD_FREE: begin
                            o_ctrl.rel_start = 1'b1;
                            n_state = S_RELEASE;
                        end
                        CMD_READ: n_state = S_READ;
                        default: n_state = S_DONE;
                    endcase
                end
            end
            S_SPLIT: begin
                o_ctrl.split = 1'b1;
                o_ctrl.take_start = 1'b1;
                n_state = S_TAKE;
            end
            S_TAKE: begin
                o_ctrl.take_step = 1'b1;
                if (i_stat.take_done) n_state = S_REMAIN;
            end
            S_REMAIN: begin
                if (!i_stat.remain_needed) begin
                    n_state = S_DONE;
                end else if (i_stat.small_ok) begin
                    o_ctrl.remain = 1'b1;
                    n_state = S_DONE;
                end else begin
                    o_ctrl.rel_start = 1'b1;
                    n_fail = 1'b1;
                    n_state = S_RELEASE;
                end
            end
            S_RELEASE: begin
                o_ctrl.rel_step = 1'b1;
                if (i_stat.rel_done) begin
                    o_ctrl.fail = r_fail;
                    n_state = S_DONE;
                end
            end
            S_READ: begin
                o_ctrl.read_issue = 1'b1;
                n_state = S_READ_WAIT;
            end
            S_READ_WAIT: begin
                o_ctrl.read_capture = 1'b1;
                n_state = S_DONE;
            end
            S_DONE: begin
                o_out_valid = 1'b1;
                if (i_out_ready) n_state = S_IDLE;
            end
            default: n_state = S_IDLE;
        endcase
    end

endmodule

// ----- rtl/greedy_multi_size_chunk_allocator_unit.sv -----
// Chunk allocator top level. An allocate scans every tag once, plus a release pass
// over all tags when it fails; a free makes one release pass over all tags and a read
// reads one tag. One item is in flight at a time: a new request is taken only once
// the last result has been accepted.
// Reset is synchronous, active low, and starts a clearing pass
// over all tags during which no item is taken.
module greedy_multi_size_chunk_allocator_unit
    import gmsca_pkg::*;
#(
    parameter int LARGE_CHUNKS  = 16,
    parameter int MEDIUM_CHUNKS = 128,
    parameter int SMALL_CHUNKS  = 2048,
    parameter int OWNER_BITS    = 8
) (
    input  logic        i_clk,
    input  logic        i_rst_n,
    input  logic        i_cfg_we,
    input  logic [31:0] i_cfg_wdata,
    input  logic        s_axis_tvalid,
    output logic        s_axis_tready,
    // cmd[1:0], request_length[32:2], owner[40:33], chunk_index[51:41]
    input  logic [55:0] s_axis_tdata,
    // pool_select[1:0]
    input  logic [1:0]  s_axis_tuser,
    output logic        m_axis_tvalid,
    input  logic        m_axis_tready,
    // status[1:0], taken_total[13:2], taken_large[18:14], taken_medium[26:19],
    // taken_small[38:27], free_large[43:39], free_medium[51:44],
    // free_small[63:52], chunk_in_use[64], chunk_owner[72:65],
    // chunk_address[104:73]
    output logic [111:0] m_axis_tdata
);

    logic [31:0] r_base;
    t_ctrl ctrl;
    t_stat stat;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) r_base <= BASE_RESET;
        else if (i_cfg_we && i_cfg_wdata != 32'd0) r_base <= i_cfg_wdata;
    end

    logic [1:0]  status;
    logic [11:0] taken_total, taken_small, free_small;
    logic [4:0]  taken_large, free_large;
    logic [7:0]  taken_medium, free_medium, chunk_owner;
    logic        chunk_in_use;
    logic [31:0] chunk_address;

    gmsca_ctrl u_ctrl (
        .i_clk(i_clk), .i_rst_n(i_rst_n), .i_in_valid(s_axis_tvalid),
        .i_cmd(s_axis_tdata[1:0]), .i_out_ready(m_axis_tready), .i_stat(stat),
        .o_ctrl(ctrl), .o_in_ready(s_axis_tready), .o_out_valid(m_axis_tvalid)
    );

    gmsca_datapath #(
        .LARGE_CHUNKS(LARGE_CHUNKS), .MEDIUM_CHUNKS(MEDIUM_CHUNKS),
        .SMALL_CHUNKS(SMALL_CHUNKS), .OWNER_BITS(OWNER_BITS)
    ) u_dp (
        .i_clk(i_clk), .i_rst_n(i_rst_n), .i_ctrl(ctrl), .o_stat(stat),
        .i_cmd(s_axis_tdata[1:0]), .i_len(s_axis_tdata[32:2]),
        .i_owner(s_axis_tdata[40:33]), .i_psel(s_axis_tuser),
        .i_idx(s_axis_tdata[51:41]), .i_base(r_base),
        .o_status(status), .o_taken_total(taken_total),
        .o_taken_large(taken_large), .o_taken_medium(taken_medium),
        .o_taken_small(taken_small), .o_free_large(free_large),
        .o_free_medium(free_medium), .o_free_small(free_small),
        .o_chunk_in_use(chunk_in_use), .o_chunk_owner(chunk_owner),
        .o_chunk_address(chunk_address)
    );

    assign m_axis_tdata = {7'd0, chunk_address, chunk_owner, chunk_in_use, free_small,
                           free_medium, free_large, taken_small, taken_medium,
                           taken_large, taken_total, status};

`ifndef SYNTHESIS
    a_no_ready_while_busy: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        m_axis_tvalid |-> !s_axis_tready)
        else $error("input ready while a result is pending");
    a_base_nonzero: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_base != 32'd0)
        else $error("base address became zero");
    a_take_sum: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        m_axis_tvalid |-> taken_total ==
        12'(taken_large) + 12'(taken_medium) + taken_small)
        else $error("taken total mismatch");
`endif

endmodule

// ----- bench/tb_greedy_multi_size_chunk_allocator_unit.sv -----
`timescale 1ns / 100ps
// Testbench for the greedy multi-size chunk allocator: drives allocate, free and read
// transfers with random gaps and stalls and checks each result against a predictor.
// Depends on gmsca_pkg and greedy_multi_size_chunk_allocator_unit.
module tb_greedy_multi_size_chunk_allocator_unit
    import gmsca_pkg::*;
();

    localparam int NL = 16;
    localparam int NM = 128;
    localparam int NS = 2048;

    typedef struct packed {
        logic [31:0] chunk_address;
        logic [7:0]  chunk_owner;
        logic        chunk_in_use;
        logic [11:0] free_small;
        logic [7:0]  free_medium;
        logic [4:0]  free_large;
        logic [11:0] taken_small;
        logic [7:0]  taken_medium;
        logic [4:0]  taken_large;
        logic [11:0] taken_total;
        logic [1:0]  status;
    } t_alloc_result;

    class alloc_scoreboard;
        logic [31:0] base;
        logic [8:0] tags[3][NS];
        int free_cnt[3];
        t_alloc_result pending[$];
        int errors;

        function new();
            base = BASE_RESET;
            for (int p = 0; p < 3; p++) begin
                for (int i = 0; i < NS; i++) tags[p][i] = '0;
            end
            free_cnt[0] = NL;
            free_cnt[1] = NM;
            free_cnt[2] = NS;
            errors = 0;
        endfunction

        function int depth(int p);
            return (p == 0) ? NL : (p == 1) ? NM : NS;
        endfunction

        function void release_owner(logic [7:0] who);
            for (int p = 0; p < 3; p++) begin
                for (int i = 0; i < depth(p); i++) begin
                    if (tags[p][i] == {1'b1, who}) begin
                        tags[p][i] = '0;
                        free_cnt[p]++;
                    end
                end
            end
        endfunction

        function int take(int p, longint n, logic [7:0] who);
            int got;
            got = 0;
            for (int i = 0; i < depth(p) && got < n; i++) begin
                if (!tags[p][i][8]) begin
                    tags[p][i] = {1'b1, who};
                    got++;
                end
            end
            free_cnt[p] -= got;
            return got;
        endfunction

        function void write_base(logic [31:0] v);
            if (v != 0) base = v;
        endfunction

        function void note_request(logic [1:0] cmd, logic [30:0] rlen, logic [7:0] who,
                                   logic [1:0] psel, logic [10:0] idx);
            t_alloc_result r;
            longint len, req;
            longint sz[3];
            int got[3];
            logic [63:0] off;
            sz[0] = 64'h10_0000;
            sz[1] = 64'h1_0000;
            sz[2] = 64'h1000;
            r = '0;
            got = '{0, 0, 0};
            len = longint'(rlen);
            if (cmd == CMD_ALLOC) begin
                for (int p = 0; p < 3; p++) begin
                    req = len / sz[p];
                    len = len % sz[p];
                    if (req != 0) begin
                        if (free_cnt[p] < req) begin
                            len += (req - free_cnt[p]) * sz[p];
                            req = free_cnt[p];
                        end
                        got[p] = take(p, req, who);
                    end
                end
                if (len != 0) begin
                    if (free_cnt[2] > 1) begin
                        got[2] += take(2, 1, who);
                    end else begin
                        release_owner(who);
                        got = '{0, 0, 0};
                        r.status = ST_FAIL;
                    end
                end
            end else if (cmd == CMD_FREE) begin
                release_owner(who);
            end else if (cmd == CMD_READ) begin
                if (psel > 2 || idx >= depth(psel)) begin
                    r.status = ST_BAD_READ;
                end else begin
                    off = 0;
                    for (int q = 0; q < psel; q++) off += depth(q) * sz[q];
                    off += idx * sz[psel];
                    r.chunk_in_use = tags[psel][idx][8];
                    r.chunk_owner = tags[psel][idx][7:0];
                    r.chunk_address = base + off[31:0];
                end
            end
            r.taken_total = 12'(got[0] + got[1] + got[2]);
            r.taken_large = 5'(got[0]);
            r.taken_medium = 8'(got[1]);
            r.taken_small = 12'(got[2]);
            r.free_large = 5'(free_cnt[0]);
            r.free_medium = 8'(free_cnt[1]);
            r.free_small = 12'(free_cnt[2]);
            pending.push_back(r);
        endfunction

        task report(string what, logic [63:0] got, logic [63:0] want);
            $display("mismatch %s: got %0h expected %0h", what, got, want);
            errors++;
        endtask

        task check_result(t_alloc_result got);
            t_alloc_result w;
            if (pending.size() == 0) begin
                report("unexpected result", got.status, 0);
                return;
            end
            w = pending.pop_front();
            if (got.status != w.status) report("status", got.status, w.status);
            if (got.taken_total != w.taken_total)
                report("taken_total", got.taken_total, w.taken_total);
            if (got.taken_large != w.taken_large)
                report("taken_large", got.taken_large, w.taken_large);
            if (got.taken_medium != w.taken_medium)
                report("taken_medium", got.taken_medium, w.taken_medium);
            if (got.taken_small != w.taken_small)
                report("taken_small", got.taken_small, w.taken_small);
            if (got.free_large != w.free_large)
                report("free_large", got.free_large, w.free_large);
            if (got.free_medium != w.free_medium)
                report("free_medium", got.free_medium, w.free_medium);
            if (got.free_small != w.free_small)
                report("free_small", got.free_small, w.free_small);
            if (got.chunk_in_use != w.chunk_in_use)
                report("chunk_in_use", got.chunk_in_use, w.chunk_in_use);
            if (got.chunk_owner != w.chunk_owner)
                report("chunk_owner", got.chunk_owner, w.chunk_owner);
            if (got.chunk_address != w.chunk_address)
                report("chunk_address", got.chunk_address, w.chunk_address);
        endtask
    endclass

    logic         i_clk;
    logic         i_rst_n;
    logic         i_cfg_we;
    logic [31:0]  i_cfg_wdata;
    logic         s_axis_tvalid;
    logic         s_axis_tready;
    logic [55:0]  s_axis_tdata;
    logic [1:0]   s_axis_tuser;
    logic         m_axis_tvalid;
    logic         m_axis_tready;
    logic [111:0] m_axis_tdata;

    alloc_scoreboard sb;
    bit calm;
    bit hold_long;

    greedy_multi_size_chunk_allocator_unit dut (
        .i_clk(i_clk), .i_rst_n(i_rst_n),
        .i_cfg_we(i_cfg_we), .i_cfg_wdata(i_cfg_wdata),
        .s_axis_tvalid(s_axis_tvalid), .s_axis_tready(s_axis_tready),
        .s_axis_tdata(s_axis_tdata), .s_axis_tuser(s_axis_tuser),
        .m_axis_tvalid(m_axis_tvalid), .m_axis_tready(m_axis_tready),
        .m_axis_tdata(m_axis_tdata)
    );

    always begin
        i_clk = 1'b0;
        #5;
        i_clk = 1'b1;
        #5;
    end

    task send_request(logic [1:0] cmd, logic [30:0] rlen, logic [7:0] who,
                      logic [1:0] psel, logic [10:0] idx);
        if (!calm && $urandom_range(0, 3) == 0) begin
            s_axis_tvalid <= 1'b0;
            repeat ($urandom_range(1, 12)) @(negedge i_clk);
        end
        s_axis_tdata <= {4'b0, idx, who, rlen, cmd};
        s_axis_tuser <= psel;
        s_axis_tvalid <= 1'b1;
        do @(posedge i_clk); while (!s_axis_tready);
        sb.note_request(cmd, rlen, who, psel, idx);
        @(negedge i_clk);
    endtask

    task drain();
        s_axis_tvalid <= 1'b0;
        while (sb.pending.size() != 0) @(negedge i_clk);
    endtask

    task set_base(logic [31:0] v);
        drain();
        repeat (20) @(negedge i_clk);
        i_cfg_we <= 1'b1;
        i_cfg_wdata <= v;
        @(negedge i_clk);
        i_cfg_we <= 1'b0;
        sb.write_base(v);
    endtask

    task random_request();
        logic [30:0] rlen;
        int k;
        k = $urandom_range(0, 9);
        case ($urandom_range(0, 5))
            0: rlen = 31'($urandom);
            1: rlen = 31'($urandom_range(0, 32'h40_0000));
            2: rlen = 31'($urandom_range(0, 32'h4_0000));
            default: rlen = 31'($urandom_range(0, 32'h8000));
        endcase
        if (k < 5) send_request(CMD_ALLOC, rlen, 8'($urandom_range(0, 7)), 2'($urandom),
                                11'($urandom));
        else if (k < 7) send_request(CMD_FREE, 31'($urandom), 8'($urandom_range(0, 7)),
                                     2'($urandom), 11'($urandom));
        else if (k < 9) send_request(CMD_READ, 31'($urandom), 8'($urandom),
                                     2'($urandom_range(0, 3)),
                                     $urandom_range(0, 1) ? 11'($urandom)
                                                          : 11'($urandom_range(0, 20)));
        else send_request(2'd3, 31'($urandom), 8'($urandom), 2'($urandom), 11'($urandom));
    endtask

    always @(posedge i_clk) begin
        if (i_rst_n && m_axis_tvalid && m_axis_tready) begin
            sb.check_result(t_alloc_result'(m_axis_tdata[104:0]));
        end
    end

    initial begin
        int gap;
        bit held;
        held = 1'b0;
        m_axis_tready = 1'b0;
        @(posedge i_rst_n);
        forever begin
            @(negedge i_clk);
            if (hold_long && !held) begin
                held = 1'b1;
                m_axis_tready <= 1'b0;
                repeat (6000) @(negedge i_clk);
            end else if (!calm && $urandom_range(0, 3) == 0) begin
                gap = $urandom_range(1, 12);
                m_axis_tready <= 1'b0;
                repeat (gap - 1) @(negedge i_clk);
            end else begin
                m_axis_tready <= 1'b1;
            end
        end
    end

    initial begin
        #400ms;
        $display("FAIL");
        $finish;
    end

    initial begin
        sb = new();
        calm = 1'b0;
        hold_long = 1'b0;
        i_rst_n = 1'b0;
        i_cfg_we = 1'b0;
        i_cfg_wdata = '0;
        s_axis_tvalid = 1'b0;
        s_axis_tdata = '0;
        s_axis_tuser = '0;
        repeat (8) @(negedge i_clk);
        i_rst_n <= 1'b1;

        send_request(CMD_READ, 0, 0, POOL_LARGE, 0);
        send_request(CMD_ALLOC, 0, 8'd1, 0, 0);
        send_request(CMD_ALLOC, 31'h0123_4567, 8'd1, 0, 0);
        send_request(CMD_READ, 0, 0, POOL_LARGE, 0);
        send_request(CMD_READ, 0, 0, POOL_MEDIUM, 11'd127);
        send_request(CMD_READ, 0, 0, POOL_MEDIUM, 11'd128);
        send_request(CMD_READ, 0, 0, POOL_LARGE, 11'd16);
        send_request(CMD_READ, 0, 0, POOL_SMALL, 11'd2047);
        send_request(CMD_READ, 0, 0, 2'd3, 0);
        send_request(2'd3, 31'h7FFF_FFFF, 8'hFF, 2'd3, 11'h7FF);
        send_request(CMD_ALLOC, 31'd1, 8'hFF, 0, 0);
        send_request(CMD_ALLOC, 31'h7FFF_FFFF, 8'd2, 0, 0);
        send_request(CMD_ALLOC, 31'd4096 * 2000, 8'd3, 0, 0);
        send_request(CMD_ALLOC, 31'd4096 * 45, 8'd4, 0, 0);
        send_request(CMD_ALLOC, 31'd4097, 8'd5, 0, 0);
        send_request(CMD_READ, 0, 0, POOL_SMALL, 11'd2047);
        send_request(CMD_FREE, 0, 8'd3, 0, 0);
        send_request(CMD_FREE, 0, 8'd1, 0, 0);
        send_request(CMD_FREE, 0, 8'hFF, 0, 0);
        send_request(CMD_FREE, 0, 8'd4, 0, 0);

        set_base(32'h0000_0000);
        send_request(CMD_READ, 0, 0, POOL_SMALL, 11'd5);
        set_base(32'hFFFF_FFFF);
        send_request(CMD_READ, 0, 0, POOL_SMALL, 11'd2047);
        set_base(32'h0000_0001);
        send_request(CMD_READ, 0, 0, POOL_MEDIUM, 11'd9);

        hold_long = 1'b1;
        for (int n = 0; n < 8; n++)
            send_request(CMD_READ, 0, 0, 2'($urandom_range(0, 2)), 11'(n));
        drain();
        for (int n = 0; n < 120; n++) random_request();
        set_base($urandom);
        drain();
        for (int n = 0; n < 90; n++) random_request();
        set_base(BASE_RESET);
        calm = 1'b1;
        for (int n = 0; n < 40; n++) random_request();

        drain();
        repeat (2300) @(negedge i_clk);
        if (sb.errors == 0 && sb.pending.size() == 0) begin
            $display("PASS");
        end else begin
            $display("FAIL");
        end
        $finish;
    end

endmodule
